// ===== sv/voxel_run_length_decoder_defines.svh =====
// Assertion macros used by the voxel run-length decoder datapath.
`ifndef VOXEL_RUN_LENGTH_DECODER_DEFINES_SVH
`define VOXEL_RUN_LENGTH_DECODER_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define VRLD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("vrld assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define VRLD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vrld assertion failed");

`endif

// ===== sv/vrld_pkg.sv =====
// Shared types and constants of the voxel run-length decoder.
package vrld_pkg;

  localparam int DIM_W   = 9;
  localparam int POS_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 24;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam int EH_W    = 17;
  localparam int EY_W    = 17;
  localparam int PROD_W  = EH_W + POS_W;

  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam dim_t MIN_EDGE   = 9'd8;
  localparam dim_t MAX_EDGE   = 9'd256;
  localparam dim_t RST_EDGE   = 9'd32;
  localparam dim_t RST_HEIGHT = 9'd32;

  typedef enum logic {
    REG_GRID_EDGE   = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEG,
    ST_MUL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic mul;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic kept;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/vrld_if.sv =====
// Valid/ready stream interfaces for input pairs and output segments.
interface vrld_in_if;
  logic                 valid;
  logic                 ready;
  logic                 new_volume;
  vrld_pkg::byte_t      value_byte;
  vrld_pkg::byte_t      run_length;

  modport source (output valid, new_volume, value_byte, run_length, input ready);
  modport sink   (input valid, new_volume, value_byte, run_length, output ready);
endinterface

interface vrld_out_if;
  logic                 valid;
  logic                 ready;
  logic                 occupied;
  vrld_pkg::addr_t      start_address;
  vrld_pkg::dim_t       segment_length;
  logic                 last;

  modport source (output valid, occupied, start_address, segment_length, last, input ready);
  modport sink   (input valid, occupied, start_address, segment_length, last, output ready);
endinterface

// ===== sv/vrld_cfg.sv =====
// APB configuration registers (grid edge and grid height) with saturation.
module vrld_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vrld_pkg::APB_AW-1:0]   paddr,
  input  logic [vrld_pkg::APB_DW-1:0]   pwdata,
  output logic [vrld_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output vrld_pkg::dim_t                grid_edge,
  output vrld_pkg::dim_t                grid_height,
  output logic                          edge_wr
);

  vrld_pkg::dim_t     grid_edge_r, grid_edge_nxt;
  vrld_pkg::dim_t     grid_height_r, grid_height_nxt;
  vrld_pkg::dim_t     wval;
  vrld_pkg::dim_t     edge_sat;
  vrld_pkg::dim_t     height_sat;
  vrld_pkg::reg_idx_t idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = vrld_pkg::reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign wval   = pwdata[vrld_pkg::DIM_W-1:0];

  always_comb begin
    if (wval < vrld_pkg::MIN_EDGE) begin
      edge_sat = vrld_pkg::MIN_EDGE;
    end else if (wval > vrld_pkg::MAX_EDGE) begin
      edge_sat = vrld_pkg::MAX_EDGE;
    end else begin
      edge_sat = wval;
    end
    height_sat = (wval > vrld_pkg::MAX_EDGE) ? vrld_pkg::MAX_EDGE : wval;
  end

  always_comb begin
    grid_edge_nxt   = grid_edge_r;
    grid_height_nxt = grid_height_r;
    edge_wr         = 1'b0;
    if (wr_en) begin
      unique case (idx)
        vrld_pkg::REG_GRID_EDGE: begin
          grid_edge_nxt = edge_sat;
          edge_wr       = 1'b1;
        end
        vrld_pkg::REG_GRID_HEIGHT: begin
          grid_height_nxt = height_sat;
        end
        default: begin
          grid_edge_nxt = grid_edge_r;
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      vrld_pkg::REG_GRID_EDGE:   prdata = vrld_pkg::APB_DW'(grid_edge_r);
      vrld_pkg::REG_GRID_HEIGHT: prdata = vrld_pkg::APB_DW'(grid_height_r);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_edge_r   <= vrld_pkg::RST_EDGE;
      grid_height_r <= vrld_pkg::RST_HEIGHT;
    end else begin
      grid_edge_r   <= grid_edge_nxt;
      grid_height_r <= grid_height_nxt;
    end
  end

  assign grid_edge   = grid_edge_r;
  assign grid_height = grid_height_r;

endmodule

// ===== sv/vrld_ctrl.sv =====
// Controller state machine sequencing segment extraction for each input pair.
module vrld_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  vrld_pkg::sts_t sts,
  output vrld_pkg::cmd_t cmd
);

  vrld_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vrld_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = vrld_pkg::ST_SEG;
        end
      end
      vrld_pkg::ST_SEG: begin
        if (!sts.more) begin
          state_nxt = vrld_pkg::ST_IDLE;
        end else if (sts.kept) begin
          state_nxt = vrld_pkg::ST_MUL;
        end
      end
      vrld_pkg::ST_MUL: begin
        state_nxt = vrld_pkg::ST_EMIT;
      end
      vrld_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = vrld_pkg::ST_SEG;
        end
      end
      default: begin
        state_nxt = vrld_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      vrld_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      vrld_pkg::ST_SEG: begin
        cmd.step = sts.more;
      end
      vrld_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
      end
      vrld_pkg::ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vrld_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/vrld_dp.sv =====
// Datapath: voxel position, run splitting, address arithmetic and output register.
`include "voxel_run_length_decoder_defines.svh"

module vrld_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vrld_pkg::dim_t       grid_edge,
  input  vrld_pkg::dim_t       grid_height,
  input  logic                 edge_wr,
  input  logic                 new_volume,
  input  vrld_pkg::byte_t      value_byte,
  input  vrld_pkg::byte_t      run_length,
  input  vrld_pkg::cmd_t       cmd,
  output vrld_pkg::sts_t       sts,
  vrld_out_if.source           out_ch
);

  vrld_pkg::pos_t   pos_y_r, pos_y_nxt;
  vrld_pkg::pos_t   pos_z_r, pos_z_nxt;
  vrld_pkg::dim_t   pos_x_r, pos_x_nxt;
  vrld_pkg::byte_t  rem_r, rem_nxt;
  logic             occ_r;

  logic [vrld_pkg::EH_W-1:0]   eh_r;
  logic [vrld_pkg::EY_W-1:0]   ey_r;
  vrld_pkg::pos_t              zinv_r;
  vrld_pkg::dim_t              x_r;
  vrld_pkg::dim_t              keep_r;
  logic                        last_seg_r;
  logic [vrld_pkg::PROD_W-1:0] prod_r;

  logic                        out_valid_r;
  logic                        occupied_r;
  vrld_pkg::addr_t             start_address_r;
  vrld_pkg::dim_t              segment_length_r;
  logic                        last_r;

  vrld_pkg::dim_t   y_ext;
  vrld_pkg::dim_t   span;
  vrld_pkg::dim_t   rem_ext;
  vrld_pkg::dim_t   seg;
  vrld_pkg::dim_t   hspan;
  vrld_pkg::dim_t   keep;
  vrld_pkg::dim_t   y_sum;
  vrld_pkg::dim_t   z_inc;
  vrld_pkg::dim_t   x_step;
  vrld_pkg::dim_t   zinv_full;
  vrld_pkg::byte_t  rem_after;
  logic             wrap_y;
  logic             wrap_z;
  logic             seg_last;
  logic [17:0]      eh_full;
  logic [17:0]      ey_full;
  logic [vrld_pkg::PROD_W:0] addr_sum;
  logic             len_ok;

  // Split the current run at the end of the column and clip it at the height.
  always_comb begin
    y_ext     = {1'b0, pos_y_r};
    rem_ext   = {1'b0, rem_r};
    span      = grid_edge - y_ext;
    seg       = (rem_ext < span) ? rem_ext : span;
    hspan     = grid_height - y_ext;
    keep      = (hspan < seg) ? hspan : seg;
    y_sum     = y_ext + seg;
    z_inc     = {1'b0, pos_z_r} + 9'd1;
    wrap_y    = (y_sum >= grid_edge);
    wrap_z    = (z_inc >= grid_edge);
    x_step    = (wrap_y && wrap_z) ? pos_x_r + 9'd1 : pos_x_r;
    rem_after = rem_r - seg[vrld_pkg::POS_W-1:0];
    // Any later segment of this run starts at the column base and is kept,
    // so this one is final only when the run or the volume ends here.
    seg_last  = (rem_after == '0) || (x_step >= grid_edge);
    zinv_full = grid_edge - 9'd1 - {1'b0, pos_z_r};
    eh_full   = 18'(grid_edge) * 18'(grid_height);
    ey_full   = 18'(grid_edge) * 18'(y_ext);
    addr_sum  = (vrld_pkg::PROD_W+1)'(prod_r) + (vrld_pkg::PROD_W+1)'(ey_r)
              + (vrld_pkg::PROD_W+1)'(x_r);
  end

  always_comb begin
    sts.more     = (rem_r != '0) && (pos_x_r < grid_edge);
    sts.kept     = (y_ext < grid_height);
    sts.out_free = !out_valid_r || out_ch.ready;
  end

  always_comb begin
    pos_y_nxt = pos_y_r;
    pos_z_nxt = pos_z_r;
    pos_x_nxt = pos_x_r;
    rem_nxt   = rem_r;
    priority if (edge_wr) begin
      pos_y_nxt = '0;
      pos_z_nxt = '0;
      pos_x_nxt = '0;
    end else if (cmd.load) begin
      rem_nxt = run_length;
      if (new_volume) begin
        pos_y_nxt = '0;
        pos_z_nxt = '0;
        pos_x_nxt = '0;
      end
    end else if (cmd.step) begin
      rem_nxt   = rem_after;
      pos_x_nxt = x_step;
      if (wrap_y) begin
        pos_y_nxt = '0;
        pos_z_nxt = wrap_z ? '0 : z_inc[vrld_pkg::POS_W-1:0];
      end else begin
        pos_y_nxt = y_sum[vrld_pkg::POS_W-1:0];
      end
    end else begin
      rem_nxt = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_y_r <= '0;
      pos_z_r <= '0;
      pos_x_r <= '0;
      rem_r   <= '0;
    end else begin
      pos_y_r <= pos_y_nxt;
      pos_z_r <= pos_z_nxt;
      pos_x_r <= pos_x_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      occ_r <= (value_byte != '0);
    end
    if (cmd.step) begin
      eh_r       <= eh_full[vrld_pkg::EH_W-1:0];
      ey_r       <= ey_full[vrld_pkg::EY_W-1:0];
      zinv_r     <= zinv_full[vrld_pkg::POS_W-1:0];
      x_r        <= pos_x_r;
      keep_r     <= keep;
      last_seg_r <= seg_last;
    end
    if (cmd.mul) begin
      prod_r <= vrld_pkg::PROD_W'(eh_r) * vrld_pkg::PROD_W'(zinv_r);
    end
    if (cmd.emit) begin
      occupied_r       <= occ_r;
      start_address_r  <= addr_sum[vrld_pkg::ADDR_W-1:0];
      segment_length_r <= keep_r;
      last_r           <= last_seg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.occupied       = occupied_r;
  assign out_ch.start_address  = start_address_r;
  assign out_ch.segment_length = segment_length_r;
  assign out_ch.last           = last_r;

  assign len_ok = out_valid_r && (segment_length_r != '0) && (segment_length_r <= grid_edge);

  `VRLD_ASSERT_ALWAYS(a_pos_y_in_column, y_ext < grid_edge)
  `VRLD_ASSERT_ALWAYS(a_pos_x_in_volume, pos_x_r <= grid_edge)
  `VRLD_ASSERT_NEXT(a_emit_len_valid, cmd.emit, len_ok)

endmodule

// ===== sv/voxel_run_length_decoder.sv =====
// A pair is taken only from the idle state. Each kept segment then passes the split,
// multiply and add steps, the add waiting while the output register is full; each
// dropped one only steps the position, and a final step closes the pair. One pair is
// worked at a time in the segment sequencer.
// The output register holds a finished segment while the next one is computed.
// Synchronous active-low reset: grid edge and height return to 32, position to zero.
module voxel_run_length_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  vrld_in_if.sink                       in_ch,
  vrld_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vrld_pkg::APB_AW-1:0]   paddr,
  input  logic [vrld_pkg::APB_DW-1:0]   pwdata,
  output logic [vrld_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  // Current configuration, and a pulse that restarts the position when the
  // edge length is rewritten.
  vrld_pkg::dim_t grid_edge;
  vrld_pkg::dim_t grid_height;
  logic           edge_wr;

  // Command and status between the sequencer and the datapath.
  vrld_pkg::cmd_t cmd;
  vrld_pkg::sts_t sts;

  vrld_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .grid_edge   (grid_edge),
    .grid_height (grid_height),
    .edge_wr     (edge_wr)
  );

  // The controller takes a new input transaction only from its idle state,
  // then walks the run one column segment at a time.
  vrld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath keeps the voxel position, computes
  // E*H*(E-1-z) + E*y + x for every kept segment and owns the output register.
  vrld_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .grid_edge   (grid_edge),
    .grid_height (grid_height),
    .edge_wr     (edge_wr),
    .new_volume  (in_ch.new_volume),
    .value_byte  (in_ch.value_byte),
    .run_length  (in_ch.run_length),
    .cmd         (cmd),
    .sts         (sts),
    .out_ch      (out_ch)
  );

endmodule

// ===== sim/voxel_segment_checker.sv =====
// Predictor and scoreboard that watch the decoder's pair, segment and register traffic.
`timescale 1ns / 100ps

module voxel_segment_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  vrld_in_if                          in_ch,
  vrld_out_if                         out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [vrld_pkg::APB_AW-1:0] paddr,
  input  logic [vrld_pkg::APB_DW-1:0] pwdata,
  output int                          fail_count,
  output int                          pending
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic            occupied;
    vrld_pkg::addr_t start_address;
    vrld_pkg::dim_t  segment_length;
    logic            last;
  } segment_t;

  // Shadow copy of the decoder's registers and voxel walk.
  vrld_pkg::dim_t grid_edge_q;
  vrld_pkg::dim_t grid_height_q;
  vrld_pkg::pos_t pos_y_q;
  vrld_pkg::pos_t pos_z_q;
  vrld_pkg::dim_t pos_x_q;

  segment_t expected_segments[$];
  int       errors;

  // Appends one predicted segment at the tail of the queue.
  function automatic void queue_segment(input segment_t entry);
    expected_segments = {expected_segments, entry};
  endfunction

  // Walks one run through the column structure and queues every kept segment.
  task automatic decode_pair(input logic new_volume, input vrld_pkg::byte_t value_byte,
                             input vrld_pkg::byte_t run_length);
    int unsigned e, h, x, y, z, remaining, seg, keep, y_next;
    segment_t    held;
    bit          have_held;
    e         = 32'(grid_edge_q);
    h         = 32'(grid_height_q);
    x         = 32'(pos_x_q);
    y         = 32'(pos_y_q);
    z         = 32'(pos_z_q);
    remaining = 32'(run_length);
    have_held = 1'b0;
    if (new_volume) begin
      x = 0;
      y = 0;
      z = 0;
    end
    while (remaining > 0 && x < e) begin
      seg = e - y;
      if (seg > remaining) seg = remaining;
      if (y < h) begin
        // The previous segment is known not to be the final one now.
        if (have_held) queue_segment(held);
        keep = h - y;
        if (keep > seg) keep = seg;
        held.occupied       = (value_byte != '0);
        held.start_address  = vrld_pkg::addr_t'(e * h * (e - 1 - z) + e * y + x);
        held.segment_length = vrld_pkg::dim_t'(keep);
        held.last           = 1'b0;
        have_held           = 1'b1;
      end
      y_next    = y + seg;
      remaining = remaining - seg;
      if (y_next >= e) begin
        y = 0;
        z = z + 1;
        if (z >= e) begin
          z = 0;
          x = x + 1;
        end
      end else begin
        y = y_next;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      queue_segment(held);
    end
    pos_x_q = vrld_pkg::dim_t'(x);
    pos_y_q = vrld_pkg::pos_t'(y);
    pos_z_q = vrld_pkg::pos_t'(z);
  endtask

  always @(posedge clk) begin : monitor
    segment_t       got;
    segment_t       want;
    vrld_pkg::dim_t wval;
    if (!rst_n) begin
      grid_edge_q   = vrld_pkg::RST_EDGE;
      grid_height_q = vrld_pkg::RST_HEIGHT;
      pos_x_q       = '0;
      pos_y_q       = '0;
      pos_z_q       = '0;
      errors        = 0;
      expected_segments.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        wval = pwdata[vrld_pkg::DIM_W-1:0];
        case (vrld_pkg::reg_idx_t'(paddr >> 2))
          vrld_pkg::REG_GRID_EDGE: begin
            if (wval < vrld_pkg::MIN_EDGE) grid_edge_q = vrld_pkg::MIN_EDGE;
            else if (wval > vrld_pkg::MAX_EDGE) grid_edge_q = vrld_pkg::MAX_EDGE;
            else grid_edge_q = wval;
            // A new edge restarts the walk at the origin.
            pos_x_q = '0;
            pos_y_q = '0;
            pos_z_q = '0;
          end
          vrld_pkg::REG_GRID_HEIGHT:
            grid_height_q = (wval > vrld_pkg::MAX_EDGE) ? vrld_pkg::MAX_EDGE : wval;
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.occupied, out_ch.start_address, out_ch.segment_length, out_ch.last};
        if (expected_segments.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: segment with none outstanding: occ=%0b addr=%0d len=%0d last=%0b",
                     $realtime, got.occupied, got.start_address, got.segment_length, got.last);
        end else begin
          want = expected_segments.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display({"%0t: segment mismatch: expected occ=%0b addr=%0d len=%0d last=%0b,",
                        " got occ=%0b addr=%0d len=%0d last=%0b"}, $realtime,
                       want.occupied, want.start_address, want.segment_length, want.last,
                       got.occupied, got.start_address, got.segment_length, got.last);
          end
        end
      end

      if (in_ch.valid && in_ch.ready)
        decode_pair(in_ch.new_volume, in_ch.value_byte, in_ch.run_length);
    end
    fail_count <= errors;
    pending    <= expected_segments.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Top of the decoder testbench: clock, reset, pair and register stimulus, and the verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 6;
  // A pair that keeps nothing never shows up on the output, so this much quiet
  // time is left before any register write and before the verdict, for the
  // sequencer to finish even a full 255-voxel run at the smallest edge.
  localparam int DRAIN_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int RANDOM_PHASES   = 7;
  localparam int ITEMS_PER_PHASE = 37;
  localparam int LONG_HOLD       = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  vrld_in_if  in_ch ();
  vrld_out_if out_ch ();

  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [vrld_pkg::APB_AW-1:0] paddr;
  logic [vrld_pkg::APB_DW-1:0] pwdata;
  logic [vrld_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  int fail_count;
  int pending;
  int idle_cycles;

  // Handshake knobs shared by the pair sender and the result sink. A set hold_req asks
  // the sink to hold ready low once, for a long hold, before its next transaction.
  bit hold_req     = 1'b0;
  bit send_burst   = 1'b0;
  bit recv_burst   = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  voxel_run_length_decoder uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  voxel_segment_checker segment_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Offers one pair after a random gap and returns at the edge where it is taken.
  // Valid is left high so that a following pair with no gap is offered at once.
  task automatic send_pair(input logic new_volume, input vrld_pkg::byte_t value_byte,
                           input vrld_pkg::byte_t run_length);
    int gap;
    gap = send_burst ? 0 : int'($urandom_range(0, 7));
    if ($urandom_range(0, 23) == 0) send_burst = !send_burst;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.new_volume <= new_volume;
    in_ch.value_byte <= value_byte;
    in_ch.run_length <= run_length;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops offering pairs, waits until every predicted segment has been seen,
  // then gives the sequencer time to finish pairs that keep no voxel.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write: a setup phase, then the access phase that commits it.
  task automatic write_reg(input vrld_pkg::reg_idx_t idx,
                           input logic [vrld_pkg::APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result sink: stalls a random number of cycles before each transaction,
  // sometimes not at all for a stretch, and once holds off for a long time so
  // that the decoder backs up into its input.
  initial begin : result_sink
    int stall;
    bit held_once;
    held_once    = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req && !held_once) begin
        held_once = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = recv_burst ? 0 : int'($urandom_range(0, 7));
      if ($urandom_range(0, 23) == 0) recv_burst = !recv_burst;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // The watchdog restarts on any transaction or register access and ends the
  // run if the design goes quiet for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [vrld_pkg::DIM_W-1:0] edge_val;
    logic [vrld_pkg::DIM_W-1:0] height_val;
    logic                       nv;
    vrld_pkg::byte_t            vb;
    vrld_pkg::byte_t            rl;

    // Every input of the design is known from time zero.
    in_ch.valid      = 1'b0;
    in_ch.new_volume = 1'b0;
    in_ch.value_byte = '0;
    in_ch.run_length = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. With the reset geometry (edge 32, height 32) a full run
    // crosses several columns, a zero-length run produces nothing, and the
    // value byte extremes check the occupancy flag.
    send_pair(1'b1, 8'hFF, 8'd255);
    send_pair(1'b0, 8'h00, 8'd0);
    send_pair(1'b0, 8'h01, 8'd1);
    send_pair(1'b0, 8'h00, 8'd200);
    send_pair(1'b0, 8'h80, 8'd31);

    // A lower height clips the top of every column.
    wait_drained();
    write_reg(vrld_pkg::REG_GRID_HEIGHT, 32'd16);
    send_pair(1'b1, 8'h55, 8'd255);
    send_pair(1'b0, 8'hAA, 8'd48);

    // Height zero drops every voxel, so this pair yields no segment at all.
    wait_drained();
    write_reg(vrld_pkg::REG_GRID_HEIGHT, 32'd0);
    send_pair(1'b0, 8'h7F, 8'd100);

    // An edge below the minimum saturates to 8 and restarts the walk; a height
    // above the maximum saturates too and ends up taller than the cube.
    wait_drained();
    write_reg(vrld_pkg::REG_GRID_EDGE, 32'd3);
    write_reg(vrld_pkg::REG_GRID_HEIGHT, 32'd300);
    send_pair(1'b0, 8'hFF, 8'd5);
    // Starting mid-column, a full run splits into the largest number of segments.
    send_pair(1'b0, 8'h00, 8'd255);
    // These runs walk off the end of the 512-voxel cube; after that everything
    // is dropped until a new volume starts.
    send_pair(1'b0, 8'h01, 8'd255);
    send_pair(1'b0, 8'h01, 8'd255);
    send_pair(1'b0, 8'hFF, 8'd255);
    send_pair(1'b1, 8'h10, 8'd9);

    // The largest cube. Bits above the register width are ignored, so 511
    // saturates to the maximum edge.
    wait_drained();
    write_reg(vrld_pkg::REG_GRID_EDGE, 32'hFFFF_FFFF);
    write_reg(vrld_pkg::REG_GRID_HEIGHT, 32'd256);
    send_pair(1'b1, 8'hFF, 8'd255);
    send_pair(1'b0, 8'h00, 8'd255);
    send_pair(1'b0, 8'h80, 8'd1);

    // Height one keeps only the bottom voxel of each column.
    wait_drained();
    write_reg(vrld_pkg::REG_GRID_HEIGHT, 32'd1);
    send_pair(1'b1, 8'h01, 8'd255);
    send_pair(1'b0, 8'h00, 8'd2);

    // Random part. Each phase runs under its own geometry; small edges reach
    // the end of the volume often, since new volumes are rare.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          edge_val   = 9'd8;
          height_val = 9'd8;
        end
        1: begin
          edge_val   = 9'd16;
          height_val = 9'd5;
        end
        2: begin
          edge_val   = 9'd256;
          height_val = 9'd256;
        end
        default: begin
          edge_val   = $urandom_range(0, 1) ? 9'($urandom_range(0, 40))
                                            : 9'($urandom_range(0, 511));
          height_val = 9'($urandom_range(0, 300));
        end
      endcase
      wait_drained();
      write_reg(vrld_pkg::REG_GRID_EDGE, ($urandom() & ~32'h1FF) | 32'(edge_val));
      write_reg(vrld_pkg::REG_GRID_HEIGHT, ($urandom() & ~32'h1FF) | 32'(height_val));

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Back-pressure: the sink holds off while pairs keep coming.
        if (phase == 1 && i == 10) hold_req = 1'b1;
        // The sender pauses once mid-phase until the output has caught up.
        if (phase == 3 && i == 20) begin
          in_ch.valid <= 1'b0;
          do @(posedge clk); while (pending != 0);
        end
        nv = ($urandom_range(0, 15) == 0);
        case ($urandom_range(0, 3))
          0:       vb = 8'h00;
          1:       vb = 8'hFF;
          default: vb = 8'($urandom());
        endcase
        case ($urandom_range(0, 3))
          0:       rl = 8'($urandom_range(0, 3));
          1:       rl = 8'd255;
          default: rl = 8'($urandom_range(0, 255));
        endcase
        send_pair(nv, vb, rl);
      end
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
